[rtl/bldel_pkg.sv]
// shared types and constants for the bounded list with delete by value
// no dependencies; used by bldel_ctrl, bldel_dp and the top level
`default_nettype none

package bldel_pkg;

   localparam int OP_BITS       = 3;
   localparam int VALUE_IN_BITS = 16;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 5;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DELETE     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_DUMP       = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_MATCH,
      CTRL_DUMP
   } state_type;

   typedef struct packed {
      logic                   push;
      logic                   pop_head;
      logic                   pop_tail;
      logic                   latch_match;
      logic                   delete_apply;
      logic                   dump_start;
      logic                   dump_step;
      logic                   emit;
      logic [STATUS_BITS-1:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic not_found;
      logic dump_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/bldel_ctrl.sv]
// controller state machine: decodes request beats and sequences delete and dump
// depends on bldel_pkg
`default_nettype none

module bldel_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [bldel_pkg::OP_BITS-1:0] req_op,
   input  wire bldel_pkg::stat_type           stat,
   output bldel_pkg::cmd_type                 cmd
);

   bldel_pkg::state_type state_ff;
   bldel_pkg::state_type state_in;
   logic                 accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bldel_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bldel_pkg::CTRL_IDLE: begin
            if (accept) begin
               if (req_op == bldel_pkg::OP_DELETE) begin
                  state_in = bldel_pkg::CTRL_MATCH;
               end else if (req_op == bldel_pkg::OP_DUMP && !stat.count_zero) begin
                  state_in = bldel_pkg::CTRL_DUMP;
               end
            end
         end
         bldel_pkg::CTRL_MATCH: begin
            state_in = bldel_pkg::CTRL_IDLE;
         end
         bldel_pkg::CTRL_DUMP: begin
            if (stat.out_free && stat.dump_last) begin
               state_in = bldel_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = bldel_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bldel_pkg::CTRL_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               unique case (req_op)
                  bldel_pkg::OP_PUSH_FRONT: begin
                     cmd.emit = 1'b1;
                     if (stat.count_full) begin
                        cmd.emit_status = bldel_pkg::ST_FULL;
                     end else begin
                        cmd.push        = 1'b1;
                        cmd.emit_status = bldel_pkg::ST_OK;
                     end
                  end
                  bldel_pkg::OP_POP_FRONT: begin
                     cmd.emit = 1'b1;
                     if (stat.count_zero) begin
                        cmd.emit_status = bldel_pkg::ST_EMPTY;
                     end else begin
                        cmd.pop_head    = 1'b1;
                        cmd.emit_status = bldel_pkg::ST_OK;
                     end
                  end
                  bldel_pkg::OP_POP_BACK: begin
                     cmd.emit = 1'b1;
                     if (stat.count_zero) begin
                        cmd.emit_status = bldel_pkg::ST_EMPTY;
                     end else begin
                        cmd.pop_tail    = 1'b1;
                        cmd.emit_status = bldel_pkg::ST_OK;
                     end
                  end
                  bldel_pkg::OP_DELETE: begin
                     cmd.latch_match = 1'b1;
                  end
                  bldel_pkg::OP_DUMP: begin
                     if (stat.count_zero) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = bldel_pkg::ST_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bldel_pkg::CTRL_MATCH: begin
            cmd.emit = 1'b1;
            if (stat.not_found) begin
               cmd.emit_status = bldel_pkg::ST_NOTFOUND;
            end else begin
               cmd.delete_apply = 1'b1;
               cmd.emit_status  = bldel_pkg::ST_OK;
            end
         end
         bldel_pkg::CTRL_DUMP: begin
            cmd.dump_step = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/bldel_dp.sv]
// datapath: row of entry cells with per-cell compare and shift, count, dump index
// and the registered result beat; depends on bldel_pkg
`default_nettype none

module bldel_dp #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire bldel_pkg::cmd_type                      cmd,
   input  wire logic [bldel_pkg::VALUE_IN_BITS-1:0]     req_value,
   input  wire logic                                    rsp_tready,
   output bldel_pkg::stat_type                          stat,
   output logic                                         rsp_tvalid,
   output logic [bldel_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic [bldel_pkg::VALUE_IN_BITS-1:0]          rsp_value,
   output logic [bldel_pkg::COUNT_BITS-1:0]             rsp_count,
   output logic                                         rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VB    = bldel_pkg::VALUE_IN_BITS;
   localparam int CB    = bldel_pkg::COUNT_BITS;

   logic [VALUE_BITS-1:0] ent_ff [DEPTH];
   logic [VALUE_BITS-1:0] ent_in [DEPTH];
   logic [DEPTH-1:0]      hit_ff;
   logic [DEPTH-1:0]      hit_in;
   logic [DEPTH-1:0]      shift_en;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic [VALUE_BITS-1:0] val;
   logic [VALUE_BITS-1:0] dump_entry;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [bldel_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [VB-1:0]                  rsp_value_ff;
   logic [CB-1:0]                  rsp_count_ff;
   logic                           rsp_last_ff;

   assign val = VALUE_BITS'(req_value);

   // per-cell compare against the request value, masked to the live entries
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit_in[i] = (ent_ff[i] == val) && (CNT_W'(i) < count_ff);
      end
   end

   // a cell shifts down when the first match lies at or ahead of it
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         shift_en[i] = |(hit_ff & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_in[i] = ent_ff[i];
         if (cmd.push) begin
            ent_in[i] = (i == 0) ? val : ent_ff[(i > 0) ? i - 1 : 0];
         end else if (cmd.pop_head) begin
            ent_in[i] = ent_ff[(i < DEPTH - 1) ? i + 1 : i];
         end else if (cmd.delete_apply && shift_en[i]) begin
            ent_in[i] = ent_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_ff[i] <= ent_in[i];
      end
      if (cmd.latch_match) begin
         hit_ff <= hit_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_head || cmd.pop_tail || cmd.delete_apply) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.dump_start) begin
         idx_in = '0;
      end else if (cmd.dump_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign dump_entry = ent_ff[idx_ff];

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == CNT_W'(DEPTH));
   assign stat.not_found  = ~|hit_ff;
   assign stat.dump_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // result beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.emit || cmd.dump_step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_value_ff  <= '0;
         rsp_count_ff  <= CB'(count_in);
         rsp_last_ff   <= 1'b1;
      end else if (cmd.dump_step) begin
         rsp_status_ff <= bldel_pkg::ST_OK;
         rsp_value_ff  <= VB'(dump_entry);
         rsp_count_ff  <= CB'(count_in);
         rsp_last_ff   <= stat.dump_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/bounded_list_with_delete_by_value.sv]
// push and pops give their result beat in the cycle after the request beat; delete latches
// the per-cell compare, then shifts and registers its result beat in the match state; dump
// clears the dump index, then gives one entry beat per cycle while the result side accepts
// throughput: 1 request per cycle for push and pops while the result side accepts; a delete or
// a non-empty dump holds off new requests until it has finished
// reset: synchronous, clears count, dump index, controller state and result valid; entries are not cleared
`default_nettype none

module bounded_list_with_delete_by_value #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // operation[2:0], value[18:3], zero pad
   input  wire logic [bldel_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // status[1:0], entry_value[17:2], entry_count[22:18], zero pad
   output logic [bldel_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                       rsp_tlast
);

   localparam int OPB = bldel_pkg::OP_BITS;
   localparam int VB  = bldel_pkg::VALUE_IN_BITS;
   localparam int SB  = bldel_pkg::STATUS_BITS;
   localparam int CB  = bldel_pkg::COUNT_BITS;
   localparam int PAD = bldel_pkg::RSP_DATA_BITS - SB - VB - CB;

   bldel_pkg::cmd_type  cmd;
   bldel_pkg::stat_type stat;
   logic [SB-1:0]       rsp_status;
   logic [VB-1:0]       rsp_value;
   logic [CB-1:0]       rsp_count;

   bldel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[OPB-1:0]),
      .stat       (stat),
      .cmd        (cmd)
   );

   bldel_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_tdata[OPB+VB-1:OPB]),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{PAD{1'b0}}, rsp_count, rsp_value, rsp_status};

endmodule

`default_nettype wire

[dv/bounded_list_with_delete_by_value_checker.sv]
// checker for the bounded list with delete by value: watches the request and result
// streams, keeps its own copy of the list, predicts each result beat and compares it
// depends on bldel_pkg
module bounded_list_with_delete_by_value_checker #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [bldel_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [bldel_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                rsp_tlast,
   output int                                  mismatches,
   output int                                  beats_due,
   output int                                  beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB     = bldel_pkg::STATUS_BITS;
   localparam int VB     = bldel_pkg::VALUE_IN_BITS;
   localparam int CB     = bldel_pkg::COUNT_BITS;
   localparam int OPB    = bldel_pkg::OP_BITS;
   localparam int VAL_LO = SB;
   localparam int CNT_LO = SB + VB;
   localparam logic [VB-1:0] VALUE_MASK = VB'((64'd1 << VALUE_BITS) - 64'd1);

   typedef struct packed {
      logic [SB-1:0] status;
      logic [VB-1:0] entry_value;
      logic [CB-1:0] entry_count;
      logic          last;
   } list_beat_type;

   logic [VB-1:0]            list_mem [DEPTH];
   int                       list_fill;
   list_beat_type            beats_expected [$];
   int                       err_total;
   int                       seen_total;

   function automatic void expect_beat(input logic [SB-1:0] status,
                                       input logic [VB-1:0] entry_value,
                                       input logic last);
      list_beat_type beat;
      beat.status      = status;
      beat.entry_value = entry_value;
      beat.entry_count = CB'(list_fill);
      beat.last        = last;
      beats_expected.push_back(beat);
   endfunction

   function automatic void predict_list_op(input logic [OPB-1:0] op,
                                           input logic [VB-1:0] raw_value);
      logic [VB-1:0] v;
      int            hit;
      int            i;
      v = raw_value & VALUE_MASK;
      case (op)
         bldel_pkg::OP_PUSH_FRONT: begin
            if (list_fill >= DEPTH) begin
               expect_beat(bldel_pkg::ST_FULL, '0, 1'b1);
            end else begin
               for (i = list_fill; i > 0; i--) list_mem[i] = list_mem[i-1];
               list_mem[0] = v;
               list_fill++;
               expect_beat(bldel_pkg::ST_OK, '0, 1'b1);
            end
         end
         bldel_pkg::OP_POP_FRONT, bldel_pkg::OP_POP_BACK: begin
            if (list_fill == 0) begin
               expect_beat(bldel_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               if (op == bldel_pkg::OP_POP_FRONT) begin
                  for (i = 0; i < list_fill - 1; i++) list_mem[i] = list_mem[i+1];
               end
               list_fill--;
               expect_beat(bldel_pkg::ST_OK, '0, 1'b1);
            end
         end
         bldel_pkg::OP_DELETE: begin
            // first match counted from the front
            hit = -1;
            for (i = list_fill - 1; i >= 0; i--) begin
               if (list_mem[i] == v) hit = i;
            end
            if (hit < 0) begin
               expect_beat(bldel_pkg::ST_NOTFOUND, '0, 1'b1);
            end else begin
               for (i = hit; i < list_fill - 1; i++) list_mem[i] = list_mem[i+1];
               list_fill--;
               expect_beat(bldel_pkg::ST_OK, '0, 1'b1);
            end
         end
         bldel_pkg::OP_DUMP: begin
            if (list_fill == 0) begin
               expect_beat(bldel_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < list_fill; i++) begin
                  expect_beat(bldel_pkg::ST_OK, list_mem[i], i == list_fill - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void report_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t ns: result beat %0d, %s expected %0h actual %0h",
                  $time, seen_total, name, expected, actual);
         err_total++;
      end
   endfunction

   always @(posedge clock) begin
      list_beat_type beat;
      if (reset) begin
         list_fill = 0;
         beats_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_total++;
            if (beats_expected.size() == 0) begin
               $display("%0t ns: result beat %0d, expected none actual tdata %0h last %0b",
                        $time, seen_total, rsp_tdata, rsp_tlast);
               err_total++;
            end else begin
               beat = beats_expected[0];
               beats_expected.delete(0);
               report_field("status", beat.status, rsp_tdata[SB-1:0]);
               report_field("entry_value", beat.entry_value, rsp_tdata[VAL_LO +: VB]);
               report_field("entry_count", beat.entry_count, rsp_tdata[CNT_LO +: CB]);
               report_field("last", beat.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_list_op(req_tdata[OPB-1:0], req_tdata[OPB +: VB]);
         end
      end
      mismatches    <= err_total;
      beats_due     <= beats_expected.size();
      beats_checked <= seen_total;
   end

endmodule

[dv/bounded_list_with_delete_by_value_tb.sv]
// testbench top for the bounded list with delete by value: drives request beats with
// random gaps and result back-pressure, then gives the verdict
// depends on bldel_pkg, the block and bounded_list_with_delete_by_value_checker
module bounded_list_with_delete_by_value_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 16;
   localparam int VALUE_BITS   = 16;
   localparam int ITEMS        = 380;
   localparam int HOLD_AT      = 140;
   localparam int PAUSE_AT     = 260;
   localparam int QUIET_AT     = 320;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int OPB          = bldel_pkg::OP_BITS;
   localparam int VB           = bldel_pkg::VALUE_IN_BITS;
   localparam int REQ_W        = bldel_pkg::REQ_DATA_BITS;
   localparam int RSP_W        = bldel_pkg::RSP_DATA_BITS;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int               mismatches;
   int               beats_due;
   int               beats_checked;
   int               op_sent [5];
   int               unused_sent;
   int               items_sent;
   int               stall_cycles;
   bit               quiet;
   bit               sender_gaps = 1'b1;
   bit               hold_rsp;
   logic [VB-1:0]    recent_vals [8] = '{default: '0};
   int               recent_wr;

   bounded_list_with_delete_by_value #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bounded_list_with_delete_by_value_checker #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) list_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .beats_due     (beats_due),
      .beats_checked (beats_checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[bounded_list_with_delete_by_value] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // values biased toward a small set and recent pushes so deletes hit
   function automatic logic [VB-1:0] pick_value();
      case ($urandom_range(0, 4))
         0, 1: return VB'($urandom_range(0, 7));
         2: return recent_vals[$urandom_range(0, 7)];
         3: return $urandom_range(0, 1) ? {VB{1'b1}} : {VB{1'b0}};
         default: return VB'($urandom());
      endcase
   endfunction

   // drives the beat itself and waits until ready is seen; sometimes then drops valid for a random gap
   task automatic send_item(input logic [OPB-1:0] op, input logic [VB-1:0] val);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({val, op});
      do @(posedge clock); while (!req_tready);
      if (op <= bldel_pkg::OP_DUMP) begin
         op_sent[op]++;
         items_sent++;
      end else begin
         unused_sent++;
      end
      if (op == bldel_pkg::OP_PUSH_FRONT) begin
         recent_vals[recent_wr] = val;
         recent_wr = (recent_wr + 1) % 8;
      end
      if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'($urandom());
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   initial begin : result_sink
      int stall_rate;
      int iter;
      stall_rate = 1;
      iter       = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (iter % 20 == 0) stall_rate = $urandom_range(0, 3);
         iter++;
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && stall_rate != 0 && $urandom_range(1, 4) <= stall_rate) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : request_source
      int  choice;
      int  c;
      bit  hold_done;
      bit  pause_done;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty list cases and unused codes
      send_item(bldel_pkg::OP_DUMP, '0);
      send_item(bldel_pkg::OP_POP_FRONT, '0);
      send_item(bldel_pkg::OP_POP_BACK, '0);
      send_item(bldel_pkg::OP_DELETE, '0);
      for (c = int'(bldel_pkg::OP_DUMP) + 1; c < (1 << OPB); c++) send_item(OPB'(c), '1);
      // extremes, duplicates, first-match delete, not found
      send_item(bldel_pkg::OP_PUSH_FRONT, 16'h0000);
      send_item(bldel_pkg::OP_PUSH_FRONT, 16'hFFFF);
      send_item(bldel_pkg::OP_PUSH_FRONT, 16'hAAAA);
      send_item(bldel_pkg::OP_PUSH_FRONT, 16'h5555);
      send_item(bldel_pkg::OP_PUSH_FRONT, 16'hFFFF);
      send_item(bldel_pkg::OP_DUMP, 16'hFFFF);
      send_item(bldel_pkg::OP_DELETE, 16'hFFFF);
      send_item(bldel_pkg::OP_DELETE, 16'h1234);
      send_item(bldel_pkg::OP_DELETE, 16'h0000);
      send_item(bldel_pkg::OP_POP_FRONT, 16'hFFFF);
      send_item(bldel_pkg::OP_POP_BACK, 16'hFFFF);
      send_item(bldel_pkg::OP_DUMP, '0);
      send_item(bldel_pkg::OP_POP_FRONT, '0);
      send_item(bldel_pkg::OP_DUMP, '0);

      while (items_sent < ITEMS) begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_rsp  = 1'b1;
         end
         if (!pause_done && items_sent >= PAUSE_AT) begin
            pause_done = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (beats_due != 0);
         end
         if (items_sent >= QUIET_AT) quiet = 1'b1;
         if (items_sent % 50 == 0) sender_gaps = $urandom_range(0, 1);
         choice = $urandom_range(0, 99);
         if (choice < 6) begin
            repeat (DEPTH + 2) send_item(bldel_pkg::OP_PUSH_FRONT, pick_value());
            send_item(bldel_pkg::OP_DUMP, pick_value());
         end else if (choice < 12) begin
            repeat (DEPTH + 2) begin
               send_item($urandom_range(0, 1) ? bldel_pkg::OP_POP_FRONT :
                         bldel_pkg::OP_POP_BACK, pick_value());
            end
         end else if (choice < 45) begin
            send_item(bldel_pkg::OP_PUSH_FRONT, pick_value());
         end else if (choice < 55) begin
            send_item(bldel_pkg::OP_POP_FRONT, pick_value());
         end else if (choice < 65) begin
            send_item(bldel_pkg::OP_POP_BACK, pick_value());
         end else if (choice < 82) begin
            send_item(bldel_pkg::OP_DELETE, pick_value());
         end else if (choice < 96) begin
            send_item(bldel_pkg::OP_DUMP, pick_value());
         end else begin
            send_item(OPB'($urandom_range(int'(bldel_pkg::OP_DUMP) + 1, (1 << OPB) - 1)),
                      pick_value());
         end
      end

      quiet = 1'b1;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (beats_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("requests sent: push %0d, pop front %0d, pop back %0d, delete %0d, dump %0d",
               op_sent[bldel_pkg::OP_PUSH_FRONT], op_sent[bldel_pkg::OP_POP_FRONT],
               op_sent[bldel_pkg::OP_POP_BACK], op_sent[bldel_pkg::OP_DELETE],
               op_sent[bldel_pkg::OP_DUMP]);
      $display("unused codes %0d, result beats compared %0d, mismatches %0d",
               unused_sent, beats_checked, mismatches);
      if (mismatches == 0) begin
         $display("[bounded_list_with_delete_by_value] OK");
      end else begin
         $display("[bounded_list_with_delete_by_value] ERROR");
      end
      $finish;
   end

endmodule
